@@ rtl/qft_pkg.sv @@
// Shared types, codes and helpers for the quoted field tokenizer.
`default_nettype none

package qft_pkg;

    localparam int MAX_TOKEN_SLOTS_DEF = 64;

    // Sticky status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_QDELIM = 2'd1;
    localparam logic [1:0] ST_UNTERM = 2'd2;
    localparam logic [1:0] ST_OVFL   = 2'd3;

    // One classified byte, front to back.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_quote;
        logic       is_delim;
        logic       is_space;
        logic       is_zero;
        logic       quote_clash;
    } qft_item_t;

    // A zero delimiter slot matches nothing.
    function automatic logic delim_hit(input logic [7:0] b, input logic [7:0] da,
                                       input logic [7:0] db, input logic [7:0] dc,
                                       input logic [7:0] dd);
        delim_hit = (b != 8'd0) && ((b == da) || (b == db) || (b == dc) || (b == dd));
    endfunction

endpackage

`default_nettype wire

@@ rtl/quoted_field_tokenizer_top.sv @@
// Top level of the quoted field tokenizer: register file, front, queue and back.
//
//   Port group   Direction  Handshake         Carries
//   s_*          in         s_valid/s_ready   one line byte and its last flag
//   m_*          out        m_valid/m_ready   one result per byte
//   p*           in/out     APB, pready = 1   seven settings at byte address 4*i
//
// Sustains one byte per cycle while m_ready stays high; a byte is written into the
// queue when taken, and the back registers its result when it pops the byte.
// The back state machine updates once per byte it takes, which sets the rate.
// Reset is synchronous on aresetn low: settings return to their defaults and
// the queue, line state and result register are emptied.
// While a result waits on m_ready the two-entry queue soaks up bytes until it
// holds two; s_ready drops only when the queue is full.
`default_nettype none

module quoted_field_tokenizer_top #(
    parameter int MAX_TOKEN_SLOTS = qft_pkg::MAX_TOKEN_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_char,
    input  wire logic        s_in_last,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_is_token_byte,
    output logic             m_token_restart,
    output logic             m_token_end,
    output logic [5:0]       m_token_index,
    output logic [6:0]       m_token_total,
    output logic             m_done_res,
    output logic [1:0]       m_status,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // register numbers (byte address / 4)
    localparam logic [2:0] REG_DELIM_A = 3'd0;
    localparam logic [2:0] REG_DELIM_B = 3'd1;
    localparam logic [2:0] REG_DELIM_C = 3'd2;
    localparam logic [2:0] REG_DELIM_D = 3'd3;
    localparam logic [2:0] REG_QUOTE   = 3'd4;
    localparam logic [2:0] REG_KEEP    = 3'd5;
    localparam logic [2:0] REG_MAXTOK  = 3'd6;

    logic [7:0] delim_a_reg, delim_b_reg, delim_c_reg, delim_d_reg, quote_reg;
    logic       keep_reg;
    logic [6:0] maxtok_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_a_reg <= 8'd32;
            delim_b_reg <= 8'd0;
            delim_c_reg <= 8'd0;
            delim_d_reg <= 8'd0;
            quote_reg   <= 8'd0;
            keep_reg    <= 1'b0;
            maxtok_reg  <= 7'd64;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DELIM_A: delim_a_reg <= pwdata[7:0];
                REG_DELIM_B: delim_b_reg <= pwdata[7:0];
                REG_DELIM_C: delim_c_reg <= pwdata[7:0];
                REG_DELIM_D: delim_d_reg <= pwdata[7:0];
                REG_QUOTE:   quote_reg   <= pwdata[7:0];
                REG_KEEP:    keep_reg    <= pwdata[0];
                REG_MAXTOK:  maxtok_reg  <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DELIM_A: prdata = {24'd0, delim_a_reg};
            REG_DELIM_B: prdata = {24'd0, delim_b_reg};
            REG_DELIM_C: prdata = {24'd0, delim_c_reg};
            REG_DELIM_D: prdata = {24'd0, delim_d_reg};
            REG_QUOTE:   prdata = {24'd0, quote_reg};
            REG_KEEP:    prdata = {31'd0, keep_reg};
            REG_MAXTOK:  prdata = {25'd0, maxtok_reg};
            default:     prdata = 32'd0;
        endcase
    end

    qft_pkg::qft_item_t front_item;
    qft_pkg::qft_item_t head_item;
    logic               q_can_push, q_can_pop, q_pop;

    qft_front u_front (
        .in_char    (s_in_char),
        .in_last    (s_in_last),
        .delim_a    (delim_a_reg),
        .delim_b    (delim_b_reg),
        .delim_c    (delim_c_reg),
        .delim_d    (delim_d_reg),
        .quote_char (quote_reg),
        .item       (front_item)
    );

    assign s_ready = q_can_push;

    qft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && q_can_push),
        .push_item (front_item),
        .can_push  (q_can_push),
        .pop       (q_pop),
        .can_pop   (q_can_pop),
        .head      (head_item)
    );

    qft_back #(
        .MAX_TOKEN_SLOTS (MAX_TOKEN_SLOTS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .keep_spaces     (keep_reg),
        .max_tokens      (maxtok_reg),
        .item_valid      (q_can_pop),
        .item            (head_item),
        .item_take       (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_is_token_byte (m_is_token_byte),
        .m_token_restart (m_token_restart),
        .m_token_end     (m_token_end),
        .m_token_index   (m_token_index),
        .m_token_total   (m_token_total),
        .m_done_res      (m_done_res),
        .m_status        (m_status)
    );

endmodule

`default_nettype wire

@@ rtl/qft_front.sv @@
// Front end: classifies each incoming byte against the delimiter and quote settings.
`default_nettype none

module qft_front (
    input  wire logic [7:0]        in_char,
    input  wire logic              in_last,
    input  wire logic [7:0]        delim_a,
    input  wire logic [7:0]        delim_b,
    input  wire logic [7:0]        delim_c,
    input  wire logic [7:0]        delim_d,
    input  wire logic [7:0]        quote_char,
    output qft_pkg::qft_item_t     item
);

    always_comb begin
        item.ch          = in_char;
        item.last        = in_last;
        item.is_quote    = (quote_char != 8'd0) && (in_char == quote_char);
        item.is_delim    = qft_pkg::delim_hit(in_char, delim_a, delim_b, delim_c, delim_d);
        item.is_space    = (in_char == 8'd32);
        item.is_zero     = (in_char == 8'd0);
        // quote byte also listed as a delimiter: line is rejected on its first byte
        item.quote_clash = (quote_char != 8'd0) &&
                           qft_pkg::delim_hit(quote_char, delim_a, delim_b, delim_c, delim_d);
    end

endmodule

`default_nettype wire

@@ rtl/qft_queue.sv @@
// Two-entry queue of classified bytes between front and back.
`default_nettype none

module qft_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire qft_pkg::qft_item_t push_item,
    output logic                    can_push,
    input  wire logic               pop,
    output logic                    can_pop,
    output qft_pkg::qft_item_t      head
);

    qft_pkg::qft_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign can_push = (count_reg != 2'd2);
    assign can_pop  = (count_reg != 2'd0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/qft_back.sv @@
// Back end: token state machine and the result register.
`default_nettype none

module qft_back #(
    parameter int MAX_TOKEN_SLOTS = qft_pkg::MAX_TOKEN_SLOTS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               keep_spaces,
    input  wire logic [6:0]         max_tokens,
    input  wire logic               item_valid,
    input  wire qft_pkg::qft_item_t item,
    output logic                    item_take,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_char,
    output logic                    m_is_token_byte,
    output logic                    m_token_restart,
    output logic                    m_token_end,
    output logic [5:0]              m_token_index,
    output logic [6:0]              m_token_total,
    output logic                    m_done_res,
    output logic [1:0]              m_status
);

    localparam int SlotCap = (MAX_TOKEN_SLOTS > 127) ? 127 : MAX_TOKEN_SLOTS;

    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_SPACE = 3'd1;
    localparam logic [2:0] PH_FIELD = 3'd2;
    localparam logic [2:0] PH_FENCE = 3'd3;
    localparam logic [2:0] PH_AFTER = 3'd4;
    localparam logic [2:0] PH_TAIL  = 3'd5;

    logic [2:0] phase_reg,  phase_next;
    logic [6:0] tokens_reg, tokens_next;
    logic [1:0] err_reg,    err_next;
    logic       stop_reg,   stop_next;
    logic       fresh_reg,  fresh_next;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_tok_reg, out_rst_reg, out_end_reg, out_done_reg;
    logic [5:0] out_idx_reg;
    logic [6:0] out_total_reg;
    logic [1:0] out_status_reg;

    logic [6:0] limit;
    logic       tok, rst, tend, ending, lim, handled;
    logic [2:0] ph;
    logic [6:0] td;
    logic [1:0] err;
    logic       stop;

    // 0 acts as 1, values above the slot count saturate
    always_comb begin
        if (max_tokens == 7'd0) begin
            limit = 7'd1;
        end else if (32'(max_tokens) > SlotCap) begin
            limit = 7'(SlotCap);
        end else begin
            limit = max_tokens;
        end
    end

    assign item_take = item_valid && (!out_valid_reg || m_ready);

    always_comb begin
        tok     = 1'b0;
        rst     = 1'b0;
        tend    = 1'b0;
        ph      = phase_reg;
        td      = tokens_reg;
        err     = err_reg;
        stop    = stop_reg;
        ending  = item.last;
        lim     = 1'b0;
        handled = 1'b0;

        if (fresh_reg && item.quote_clash) begin
            err  = qft_pkg::ST_QDELIM;
            stop = 1'b1;
        end

        if (!stop) begin
            if (item.is_zero) begin
                ending = 1'b1;
                stop   = 1'b1;
            end else begin
                lim = (td >= limit);
                // one delimiter after a closing quote is swallowed
                if (ph == PH_AFTER) begin
                    ph      = lim ? PH_TAIL : PH_SKIP;
                    handled = item.is_delim;
                end
                if (!handled) begin
                    case (ph)
                        PH_SPACE: begin
                            if (item.is_quote) begin
                                rst = 1'b1;
                                ph  = PH_FENCE;
                            end else if (item.is_space) begin
                                ph  = PH_SPACE;
                            end else if (item.is_delim) begin
                                stop = 1'b1;   // empty field
                            end else begin
                                tok = 1'b1;
                                ph  = PH_FIELD;
                            end
                        end
                        PH_FIELD: begin
                            if (item.is_quote) begin
                                rst = 1'b1;
                                ph  = PH_FENCE;
                            end else if (item.is_delim) begin
                                tend = 1'b1;
                                td   = td + 7'd1;
                                ph   = (td >= limit) ? PH_TAIL : PH_SKIP;
                            end else begin
                                tok = 1'b1;
                            end
                        end
                        PH_FENCE: begin
                            if (item.is_quote) begin
                                tend = 1'b1;
                                td   = td + 7'd1;
                                ph   = PH_AFTER;
                            end else begin
                                tok = 1'b1;
                            end
                        end
                        PH_TAIL: begin
                            if (!item.is_delim) begin
                                err  = qft_pkg::ST_OVFL;
                                stop = 1'b1;
                            end
                        end
                        default: begin
                            if (item.is_quote) begin
                                rst = 1'b1;
                                ph  = PH_FENCE;
                            end else if (!keep_spaces && item.is_space) begin
                                ph  = PH_SPACE;
                            end else if (item.is_delim) begin
                                ph  = PH_SKIP;
                            end else begin
                                tok = 1'b1;
                                ph  = PH_FIELD;
                            end
                        end
                    endcase
                end
            end
            if (ending && !(stop && !item.is_zero)) begin
                if (ph == PH_FIELD) begin
                    tend = 1'b1;
                    td   = td + 7'd1;
                end else if (ph == PH_FENCE) begin
                    err = qft_pkg::ST_UNTERM;
                end
                stop = 1'b1;
            end
        end

        if (item.last) begin
            phase_next  = PH_SKIP;
            tokens_next = 7'd0;
            err_next    = qft_pkg::ST_OK;
            stop_next   = 1'b0;
            fresh_next  = 1'b1;
        end else begin
            phase_next  = ph;
            tokens_next = td;
            err_next    = err;
            stop_next   = stop;
            fresh_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            tokens_reg    <= 7'd0;
            err_reg       <= qft_pkg::ST_OK;
            stop_reg      <= 1'b0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_take) begin
                phase_reg  <= phase_next;
                tokens_reg <= tokens_next;
                err_reg    <= err_next;
                stop_reg   <= stop_next;
                fresh_reg  <= fresh_next;
            end
            if (item_take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            out_char_reg   <= item.ch;
            out_tok_reg    <= tok;
            out_rst_reg    <= rst;
            out_end_reg    <= tend;
            out_idx_reg    <= tokens_reg[5:0];
            out_total_reg  <= td;
            out_done_reg   <= item.last;
            out_status_reg <= err;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_char      = out_char_reg;
    assign m_is_token_byte = out_tok_reg;
    assign m_token_restart = out_rst_reg;
    assign m_token_end     = out_end_reg;
    assign m_token_index   = out_idx_reg;
    assign m_token_total   = out_total_reg;
    assign m_done_res      = out_done_reg;
    assign m_status        = out_status_reg;

    a_no_restart_and_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_rst_reg && out_end_reg))
        else $error("restart and token end on one result");

    // an open quote at line end still carries its byte flags
    a_token_flags_need_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_tok_reg || out_rst_reg || out_end_reg))
            |-> ((out_status_reg != qft_pkg::ST_QDELIM) &&
                 (out_status_reg != qft_pkg::ST_OVFL)))
        else $error("token activity after a stopping error");

    a_line_end_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item.last) |=> (fresh_reg && !stop_reg && tokens_reg == 7'd0))
        else $error("line state not cleared after last byte");

    a_error_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != qft_pkg::ST_OK) |-> stop_reg)
        else $error("error recorded while still parsing");

endmodule

`default_nettype wire
